@@ rtl/idba_pkg.sv @@
package idba_pkg;

    typedef struct packed {
        logic [31:0] slot_start;
        logic [31:0] slot_end;
    } t_req;

    typedef struct packed {
        logic       accepted;
        logic [1:0] status;
    } t_resp;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_TRIPLE = 2'd1;
    localparam logic [1:0] STATUS_FULL   = 2'd2;

endpackage

@@ rtl/interval_double_booking_admitter.sv @@
// Admits reservations of half-open intervals [slot_start, slot_end) while no point in time
// is booked more than twice. Accepted intervals and doubly booked regions sit in two
// single-port-style memories with a registered read. A request first scans the double
// table one entry per cycle (stopping early on a triple overlap), then scans the reservation
// table one entry per cycle, writing each intersection speculatively behind the committed
// end of the double table; only the final check commits the counts. One request is worked
// at a time; a new word is taken while the previous result still waits on the output
// register. Status 1 means a triple overlap, status 2 means a table would overflow; in
// both cases nothing changes. Inputs are cut or zero-extended to TIME_BITS. No clearing
// pass is needed after reset.
module interval_double_booking_admitter #(
    parameter int MAX_RESERVATIONS   = 64,
    parameter int MAX_DOUBLE_REGIONS = 128,
    parameter int TIME_BITS          = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  idba_pkg::t_req   i_in_word,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output idba_pkg::t_resp  o_out_word
);
    import idba_pkg::*;

    localparam int RCW = $clog2(MAX_RESERVATIONS + 1);
    localparam int DCW = $clog2(MAX_DOUBLE_REGIONS + 1);
    localparam int RAW = $clog2(MAX_RESERVATIONS);
    localparam int DAW = $clog2(MAX_DOUBLE_REGIONS);
    localparam int SW  = ((DCW > RCW) ? DCW : RCW) + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DSCAN,
        S_RSCAN,
        S_FINISH
    } t_state;

    function automatic logic meets(input logic [TIME_BITS-1:0] s1, input logic [TIME_BITS-1:0] e1,
                                   input logic [TIME_BITS-1:0] s2,
                                   input logic [TIME_BITS-1:0] e2);
        logic [TIME_BITS-1:0] hi;
        logic [TIME_BITS-1:0] lo;
        hi = (s1 > s2) ? s1 : s2;
        lo = (e1 < e2) ? e1 : e2;
        return hi < lo;
    endfunction

    logic [2*TIME_BITS-1:0] r_rmem [MAX_RESERVATIONS];
    logic [2*TIME_BITS-1:0] r_dmem [MAX_DOUBLE_REGIONS];
    logic [2*TIME_BITS-1:0] r_rq;
    logic [2*TIME_BITS-1:0] r_dq;

    t_state               r_state, n_state;
    logic [TIME_BITS-1:0] r_s, n_s;
    logic [TIME_BITS-1:0] r_e, n_e;
    logic [RCW-1:0]       r_rcnt, n_rcnt;
    logic [DCW-1:0]       r_dcnt, n_dcnt;
    logic [RCW-1:0]       r_hits, n_hits;
    logic [RCW-1:0]       r_ridx, n_ridx;
    logic [DCW-1:0]       r_didx, n_didx;
    logic                 r_pend, n_pend;
    logic                 r_triple, n_triple;
    logic                 r_ovalid, n_ovalid;
    t_resp                r_out, n_out;

    logic                 w_dwe;
    logic                 w_rwe;
    logic [SW-1:0]        w_sum;
    logic [TIME_BITS-1:0] w_rs, w_re, w_ds, w_de;

    assign w_sum = SW'(r_dcnt) + SW'(r_hits);
    assign w_rs  = r_rq[2*TIME_BITS-1:TIME_BITS];
    assign w_re  = r_rq[TIME_BITS-1:0];
    assign w_ds  = r_dq[2*TIME_BITS-1:TIME_BITS];
    assign w_de  = r_dq[TIME_BITS-1:0];

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_word  = r_out;

    always_ff @(posedge i_clk) begin
        r_rq <= r_rmem[r_ridx[RAW-1:0]];
        if (w_rwe) begin
            r_rmem[r_rcnt[RAW-1:0]] <= {r_s, r_e};
        end
    end

    always_ff @(posedge i_clk) begin
        r_dq <= r_dmem[r_didx[DAW-1:0]];
        if (w_dwe) begin
            r_dmem[w_sum[DAW-1:0]] <= {(w_rs > r_s) ? w_rs : r_s, (w_re < r_e) ? w_re : r_e};
        end
    end

    always_comb begin
        n_state  = r_state;
        n_s      = r_s;
        n_e      = r_e;
        n_rcnt   = r_rcnt;
        n_dcnt   = r_dcnt;
        n_hits   = r_hits;
        n_ridx   = r_ridx;
        n_didx   = r_didx;
        n_pend   = r_pend;
        n_triple = r_triple;
        n_ovalid = r_ovalid;
        n_out    = r_out;
        w_dwe    = 1'b0;
        w_rwe    = 1'b0;

        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_s      = TIME_BITS'(i_in_word.slot_start);
                    n_e      = TIME_BITS'(i_in_word.slot_end);
                    n_didx   = '0;
                    n_ridx   = '0;
                    n_hits   = '0;
                    n_pend   = 1'b0;
                    n_triple = 1'b0;
                    n_state  = S_DSCAN;
                end
            end
            S_DSCAN: begin
                if (r_pend && meets(w_ds, w_de, r_s, r_e)) begin
                    n_triple = 1'b1;
                    n_pend   = 1'b0;
                    n_state  = S_FINISH;
                end else if (r_didx != r_dcnt) begin
                    n_didx = r_didx + 1'b1;
                    n_pend = 1'b1;
                end else begin
                    n_pend  = 1'b0;
                    n_state = S_RSCAN;
                end
            end
            S_RSCAN: begin
                if (r_pend && meets(w_rs, w_re, r_s, r_e)) begin
                    n_hits = r_hits + 1'b1;
                    // speculative write past the committed end of the double table
                    w_dwe  = (w_sum < SW'(MAX_DOUBLE_REGIONS));
                end
                if (r_ridx != r_rcnt) begin
                    n_ridx = r_ridx + 1'b1;
                    n_pend = 1'b1;
                end else begin
                    n_pend  = 1'b0;
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (!r_ovalid || i_out_ready) begin
                    n_ovalid = 1'b1;
                    n_state  = S_IDLE;
                    priority if (r_triple) begin
                        n_out = '{accepted: 1'b0, status: STATUS_TRIPLE};
                    end else if (r_rcnt == RCW'(MAX_RESERVATIONS) ||
                                 w_sum > SW'(MAX_DOUBLE_REGIONS)) begin
                        n_out = '{accepted: 1'b0, status: STATUS_FULL};
                    end else begin
                        n_out  = '{accepted: 1'b1, status: STATUS_OK};
                        w_rwe  = 1'b1;
                        n_rcnt = r_rcnt + 1'b1;
                        n_dcnt = DCW'(w_sum);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_rcnt   <= '0;
            r_dcnt   <= '0;
            r_hits   <= '0;
            r_ridx   <= '0;
            r_didx   <= '0;
            r_pend   <= 1'b0;
            r_triple <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rcnt   <= n_rcnt;
            r_dcnt   <= n_dcnt;
            r_hits   <= n_hits;
            r_ridx   <= n_ridx;
            r_didx   <= n_didx;
            r_pend   <= n_pend;
            r_triple <= n_triple;
            r_ovalid <= n_ovalid;
        end
        r_s   <= n_s;
        r_e   <= n_e;
        r_out <= n_out;
    end

endmodule

@@ tb/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import idba_pkg::*;

    localparam int BOOK_DEPTH  = 64;
    localparam int TWICE_DEPTH = 128;
    localparam int TAIL_CYCLES = 256;
    localparam int CYCLE_LIMIT = 4_000_000;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_in_valid;
    logic  o_in_ready;
    t_req  i_in_word;
    logic  o_out_valid;
    logic  i_out_ready;
    t_resp o_out_word;

    interval_double_booking_admitter u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    // model state: booked intervals and twice-covered regions
    logic [31:0] booked_lo [BOOK_DEPTH];
    logic [31:0] booked_hi [BOOK_DEPTH];
    int          booked_n;
    logic [31:0] twice_lo  [TWICE_DEPTH];
    logic [31:0] twice_hi  [TWICE_DEPTH];
    int          twice_n;

    t_resp       verdicts_due [$];
    t_resp       due;
    int          mismatches;
    int          cycles;
    int          send_idle_pct;
    int          recv_stall_pct;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout", $time);
            $display("interval_double_booking_admitter test failed");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_ready = ($urandom_range(0, 99) >= recv_stall_pct);
    end

    function automatic bit overlaps(logic [31:0] s1, logic [31:0] e1,
                                    logic [31:0] s2, logic [31:0] e2);
        logic [31:0] lo;
        logic [31:0] hi;
        lo = (s1 > s2) ? s1 : s2;
        hi = (e1 < e2) ? e1 : e2;
        return lo < hi;
    endfunction

    function automatic t_resp book_interval(t_req r);
        t_resp      rsp;
        int         hits;
        logic [1:0] st;
        st   = STATUS_OK;
        hits = 0;
        for (int i = 0; i < twice_n; i++) begin
            if (overlaps(twice_lo[i], twice_hi[i], r.slot_start, r.slot_end))
                st = STATUS_TRIPLE;
        end
        if (st == STATUS_OK) begin
            for (int i = 0; i < booked_n; i++) begin
                if (overlaps(booked_lo[i], booked_hi[i], r.slot_start, r.slot_end))
                    hits++;
            end
            if (booked_n >= BOOK_DEPTH || twice_n + hits > TWICE_DEPTH)
                st = STATUS_FULL;
        end
        if (st == STATUS_OK) begin
            for (int i = 0; i < booked_n; i++) begin
                if (overlaps(booked_lo[i], booked_hi[i], r.slot_start, r.slot_end)) begin
                    twice_lo[twice_n] = (booked_lo[i] > r.slot_start) ? booked_lo[i]
                                                                      : r.slot_start;
                    twice_hi[twice_n] = (booked_hi[i] < r.slot_end) ? booked_hi[i]
                                                                    : r.slot_end;
                    twice_n++;
                end
            end
            booked_lo[booked_n] = r.slot_start;
            booked_hi[booked_n] = r.slot_end;
            booked_n++;
        end
        rsp.accepted = (st == STATUS_OK);
        rsp.status   = st;
        return rsp;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ($isunknown(o_out_valid)) begin
                mismatches++;
                $display("%0t: o_out_valid unknown", $time);
            end else if (o_out_valid && i_out_ready) begin
                if (verdicts_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected word accepted=%0d status=%0d", $time,
                             o_out_word.accepted, o_out_word.status);
                end else begin
                    due = verdicts_due.pop_front();
                    if (o_out_word.accepted !== due.accepted) begin
                        mismatches++;
                        $display("%0t: accepted expected %0d got %0d", $time,
                                 due.accepted, o_out_word.accepted);
                    end
                    if (o_out_word.status !== due.status) begin
                        mismatches++;
                        $display("%0t: status expected %0d got %0d", $time,
                                 due.status, o_out_word.status);
                    end
                end
            end
        end
    end

    task automatic send_req(input logic [31:0] s, input logic [31:0] e);
        t_req w;
        w.slot_start = s;
        w.slot_end   = e;
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            i_in_word  = {$urandom, $urandom};
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_word  = w;
        do @(posedge i_clk); while (!o_in_ready);
        verdicts_due.insert(verdicts_due.size(), book_interval(w));
    endtask

    task automatic wait_all_answered();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (verdicts_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed_cases();
        send_req(32'd100, 32'd200);
        send_req(32'd150, 32'd250);
        send_req(32'd180, 32'd190);
        send_req(32'd199, 32'd200);
        send_req(32'd200, 32'd300);
        send_req(32'd0, 32'd100);
        send_req(32'd150, 32'd150);
        send_req(32'hFFFF_FFFF, 32'd0);
        send_req(32'd0, 32'hFFFF_FFFF);
        send_req(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        // comb of unit slots, then one interval spanning them all
        for (int k = 0; k < 10; k++)
            send_req(32'd1000 + 2 * k, 32'd1001 + 2 * k);
        send_req(32'd1000, 32'd1020);
        send_req(32'd1005, 32'd1006);
        send_req(32'd1000, 32'd1020);
        wait_all_answered();
    endtask

    task automatic test_random_traffic(input int n, input int idle_pct, input int stall_pct);
        int          kind;
        logic [31:0] s;
        logic [31:0] e;
        logic [31:0] base;
        logic [32:0] sum;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < n; i++) begin
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                case ($urandom_range(0, 2))
                    0: base = 32'd0;
                    1: base = 32'h8000_0000;
                    default: base = 32'hFFFF_F000;
                endcase
                s   = base + $urandom_range(0, 4095);
                sum = {1'b0, s} + $urandom_range(1, 300);
                e   = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            end else if (kind < 80) begin
                s = $urandom;
                e = $urandom_range(s, 0);
            end else if (kind < 90) begin
                s = $urandom;
                e = $urandom;
            end else begin
                s = $urandom_range(0, 1000);
                e = 32'hFFFF_FFFF - $urandom_range(0, 1000);
            end
            send_req(s, e);
        end
        wait_all_answered();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_word      = '0;
        i_out_ready    = 1'b0;
        booked_n       = 0;
        twice_n        = 0;
        mismatches     = 0;
        cycles         = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_cases();
        test_random_traffic(420, 0, 0);
        test_random_traffic(420, 54, 0);
        test_random_traffic(420, 0, 54);
        test_random_traffic(420, 11, 11);

        wait_all_answered();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("interval_double_booking_admitter test passed");
        end else begin
            $display("interval_double_booking_admitter test failed");
        end
        $finish;
    end
endmodule
